// File: rtl/tli_pkg.sv
`default_nettype none

package tli_pkg;

  localparam int DATA_W     = 32;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int COUNT_W    = 7;
  localparam int PADDR_W    = 3;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_INSET       = 1'b1;

  typedef enum logic [1:0] {
    STAT_INTERP = 2'd0,
    STAT_LOW    = 2'd1,
    STAT_HIGH   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SEARCH,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/table_linear_interpolator.sv
// Load transfer: accepted only in idle, written to the table at the accept edge, no result.
// Query: the low end is settled after the first table read, the high end after the read
// of the last point; inside the table one table read per search step (up to log2 of the
// point count), then the bit-serial fraction divider, a multiply and a saturating add.
// One query in flight at a time; a finished result waits in the output register.
// Active-high sync reset clears control, x range, inset; point count to 2; table unset.
`default_nettype none

module table_linear_interpolator
  import tli_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // APB configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     operation,
  input  wire logic [IDX_W-1:0]         point_index,
  input  wire logic signed [DATA_W-1:0] point_x,
  input  wire logic signed [DATA_W-1:0] point_y,
  input  wire logic signed [DATA_W-1:0] query_value,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      result_value,
  output logic [IDX_W-1:0]              segment_index,
  output logic [FRAC_BITS:0]            fraction,
  output logic [1:0]                    status
);

  localparam int FRAC_W = FRAC_BITS + 1;
  localparam int EXT_W  = DATA_W + 1;
  localparam int PROD_W = EXT_W + FRAC_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [EXT_W-1:0] ONE_EXT =
    {{(EXT_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // configuration
  logic [COUNT_W-1:0] point_count;
  logic               inset_enable;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= COUNT_W'(2);
      inset_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_POINT_COUNT: point_count  <= pwdata[COUNT_W-1:0];
        REG_INSET:       inset_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POINT_COUNT: prdata = {{(32 - COUNT_W){1'b0}}, point_count};
      REG_INSET:       prdata = {31'b0, inset_enable};
      default:         prdata = '0;
    endcase
  end

  // index of the last point in use, point count clamped to 2..MAX_POINTS
  logic [IDX_W-1:0] n_last;
  always_comb begin
    if (point_count < COUNT_W'(2))
      n_last = IDX_W'(1);
    else if (point_count > COUNT_W'(MAX_POINTS))
      n_last = IDX_W'(MAX_POINTS - 1);
    else
      n_last = IDX_W'(point_count - COUNT_W'(1));
  end

  // table
  logic                     tbl_wr;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [DATA_W-1:0] rd_x, rd_y;
  logic signed [DATA_W-1:0] x_lowest, x_highest;

  assign tbl_wr = in_valid & in_ready & (operation == OP_LOAD);

  tli_table u_table (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (tbl_wr),
    .wr_addr   (point_index),
    .wr_x      (point_x),
    .wr_y      (point_y),
    .rd_addr   (rd_addr),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .x_lowest  (x_lowest),
    .x_highest (x_highest)
  );

  // inset clamp on the incoming query
  logic signed [EXT_W-1:0]  dec_ext, inc_ext;
  logic signed [DATA_W-1:0] q_clamped;

  assign dec_ext = EXT_W'(x_highest) - ONE_EXT;
  assign inc_ext = EXT_W'(x_lowest) + ONE_EXT;

  always_comb begin
    q_clamped = query_value;
    if (inset_enable) begin
      if (query_value > x_highest)
        q_clamped = (dec_ext[EXT_W-1] != dec_ext[DATA_W-1]) ? DATA_MIN
                                                             : dec_ext[DATA_W-1:0];
      else if (query_value < x_lowest)
        q_clamped = (inc_ext[EXT_W-1] != inc_ext[DATA_W-1]) ? DATA_MAX
                                                             : inc_ext[DATA_W-1:0];
    end
  end

  // working registers
  state_t                   state, state_next;
  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] xlo, ylo, xhi, yhi;
  logic [IDX_W-1:0]         lo, hi, mid;
  logic signed [EXT_W-1:0]  dy;
  logic [FRAC_W-1:0]        frac;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] res_value;
  logic [IDX_W-1:0]         res_seg;
  logic [FRAC_W-1:0]        res_frac;
  status_t                  res_status;
  status_t                  out_status;

  // search step: rd_x holds x[mid]
  logic             go_lo;
  logic [IDX_W-1:0] lo_n, hi_n, mid_n, mid0;
  logic [IDX_W:0]   sum_n;
  logic             more_n, more0;

  assign go_lo  = (rd_x < q);
  assign lo_n   = go_lo ? mid : lo;
  assign hi_n   = go_lo ? hi : mid;
  assign sum_n  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n  = sum_n[IDX_W:1];
  assign more_n = ((hi_n - lo_n) > IDX_W'(1));
  assign mid0   = n_last >> 1;
  assign more0  = (n_last > IDX_W'(1));

  // divider operands; a bracket that is not ordered gives fraction zero
  logic signed [EXT_W-1:0] num_ext, den_ext;
  logic                    div_guard;
  logic [DATA_W:0]         div_num, div_den;
  logic                    div_start;
  div_stat_t               div_stat;
  logic [FRAC_W-1:0]       div_quot;

  assign num_ext   = EXT_W'(q) - EXT_W'(xlo);
  assign den_ext   = EXT_W'(xhi) - EXT_W'(xlo);
  assign div_guard = num_ext[EXT_W-1] | den_ext[EXT_W-1] | (den_ext == '0);
  assign div_num   = div_guard ? '0 : num_ext;
  assign div_den   = div_guard ? EXT_W'(1) : den_ext;

  tli_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // final add and saturation
  logic signed [SUM_W-1:0]  sum_val;
  logic signed [DATA_W-1:0] sat_val;

  assign sum_val = SUM_W'(ylo) + SUM_W'(prod >>> FRAC_BITS);

  always_comb begin
    if ((&sum_val[SUM_W-1:DATA_W-1]) || !(|sum_val[SUM_W-1:DATA_W-1]))
      sat_val = sum_val[DATA_W-1:0];
    else if (sum_val[SUM_W-1])
      sat_val = DATA_MIN;
    else
      sat_val = DATA_MAX;
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && operation == OP_QUERY) state_next = ST_FIRST;
      ST_FIRST:  state_next = (q <= rd_x) ? ST_DONE : ST_LAST;
      ST_LAST: begin
        if (q >= rd_x)  state_next = ST_DONE;
        else if (more0) state_next = ST_SEARCH;
        else            state_next = ST_PREP;
      end
      ST_SEARCH: if (!more_n) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DIV;
      ST_DIV:    if (div_stat.done) state_next = ST_MUL;
      ST_MUL:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    rd_addr   = '0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_FIRST:  rd_addr = n_last;
      ST_LAST:   rd_addr = mid0;
      ST_SEARCH: rd_addr = mid_n;
      ST_PREP:   div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: q <= q_clamped;
      ST_FIRST: begin
        xlo        <= rd_x;
        ylo        <= rd_y;
        res_value  <= rd_y;
        res_seg    <= '0;
        res_frac   <= '0;
        res_status <= STAT_LOW;
      end
      ST_LAST: begin
        xhi        <= rd_x;
        yhi        <= rd_y;
        lo         <= '0;
        hi         <= n_last;
        mid        <= mid0;
        res_value  <= rd_y;
        res_seg    <= n_last - IDX_W'(1);
        res_frac   <= FRAC_ONE;
        res_status <= STAT_HIGH;
      end
      ST_SEARCH: begin
        if (go_lo) begin
          lo  <= mid;
          xlo <= rd_x;
          ylo <= rd_y;
        end else begin
          hi  <= mid;
          xhi <= rd_x;
          yhi <= rd_y;
        end
        mid <= mid_n;
      end
      ST_PREP: dy <= EXT_W'(yhi) - EXT_W'(ylo);
      ST_DIV:  frac <= (div_quot > FRAC_ONE) ? FRAC_ONE : div_quot;
      ST_MUL:  prod <= dy * $signed({1'b0, frac});
      ST_SUM: begin
        res_value  <= sat_val;
        res_seg    <= lo;
        res_frac   <= frac;
        res_status <= STAT_INTERP;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result_value  <= res_value;
      segment_index <= res_seg;
      fraction      <= res_frac;
      out_status    <= res_status;
    end
  end

  assign status = out_status;

endmodule

`default_nettype wire

// File: rtl/tli_table.sv
`default_nettype none

module tli_table
  import tli_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [IDX_W-1:0]         wr_addr,
  input  wire logic signed [DATA_W-1:0] wr_x,
  input  wire logic signed [DATA_W-1:0] wr_y,
  input  wire logic [IDX_W-1:0]         rd_addr,
  output logic signed [DATA_W-1:0]      rd_x,
  output logic signed [DATA_W-1:0]      rd_y,
  output logic signed [DATA_W-1:0]      x_lowest,
  output logic signed [DATA_W-1:0]      x_highest
);

  logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] y_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

  // running x range; slot 0 restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      x_lowest  <= DATA_MAX;
      x_highest <= DATA_MIN;
    end else if (wr_en) begin
      if (wr_addr == '0) begin
        x_lowest  <= wr_x;
        x_highest <= wr_x;
      end else begin
        if (wr_x < x_lowest)  x_lowest  <= wr_x;
        if (wr_x > x_highest) x_highest <= wr_x;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tli_divider.sv
`default_nettype none

// Restoring divider: quot = floor(num * 2^FRAC_BITS / den), num <= den.
// One quotient bit per cycle, FRAC_BITS + 1 quotient bits.
module tli_divider
  import tli_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DATA_W:0]      num,
  input  wire logic [DATA_W:0]      den,
  output div_stat_t                 stat,
  output logic [FRAC_BITS:0]        quot
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  logic [DATA_W:0] rem;
  logic [DATA_W:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic            ge;
  logic [DATA_W:0] rem_sub;

  assign ge      = (rem >= dvs);
  assign rem_sub = ge ? (rem - dvs) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(FRAC_BITS + 1);
      end else if (stat.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dvs  <= den;
      quot <= '0;
    end else if (stat.busy) begin
      // remainder stays below den < 2^32, so the shift never overflows
      rem  <= {rem_sub[DATA_W-1:0], 1'b0};
      quot <= {quot[FRAC_BITS-1:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/tli_checker.sv
`default_nettype none

module tli_checker
  import tli_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     operation,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DATA_W-1:0] result_value,
  input wire logic [IDX_W-1:0]         segment_index,
  input wire logic [FRAC_BITS:0]       fraction,
  input wire logic [1:0]               status
);

  localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("stalled result transfer changed");

  a_low_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_LOW |-> segment_index == '0 && fraction == '0)
    else $error("low end result with nonzero segment or fraction");

  a_high_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_HIGH |-> fraction == FRAC_ONE)
    else $error("high end result without full fraction");

  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_QUERY |=> !$rose(out_valid))
    else $error("query result appeared one cycle after its transfer");

endmodule

bind table_linear_interpolator tli_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_tli_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .operation     (operation),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_value  (result_value),
  .segment_index (segment_index),
  .fraction      (fraction),
  .status        (status)
);

`default_nettype wire
